FILE: hw/rtl/fisf_pkg.sv
// Shared constants, types and the sequencer control program for the sample filter.
package fisf_pkg;

  localparam int ORDER          = 8;
  localparam int COEF_FRAC_BITS = 14;
  localparam int PACKED_TAPS    = 9;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int OPD_W    = SAMPLE_W + 1;
  localparam int PROD_W   = COEF_W + OPD_W;
  localparam int ACC_W    = PROD_W + $clog2(ORDER + 1);
  localparam int TAP_W    = $clog2(ORDER + 1);
  localparam int HIST_IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int NUM_STEPS = ORDER + 4;
  localparam int STEP_W   = $clog2(NUM_STEPS);
  localparam int COEF_ALL_W = 2 * CFG_W + COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_IIR_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic             wait_in;
    logic             mul_en;
    logic [TAP_W-1:0] tap;
    acc_op_t          acc_op;
    logic             finish;
  } ctl_t;

  // Step 0 waits for a sample, steps 1 to ORDER+1 multiply one tap each,
  // the accumulator takes each product from the product register in the step after it is made, and the last step
  // rounds, saturates and retires the result.
  function automatic ctl_t rom_word(logic [STEP_W-1:0] step);
    ctl_t w;
    int   s;
    w = '0;
    s = int'(step);
    if (s == 0) begin
      w.wait_in = 1'b1;
    end else if (s <= ORDER + 1) begin
      w.mul_en = 1'b1;
      w.tap    = TAP_W'(s - 1);
      if (s == 2) begin
        w.acc_op = ACC_LOAD;
      end else if (s > 2) begin
        w.acc_op = ACC_ADD;
      end
    end else if (s == ORDER + 2) begin
      w.acc_op = ACC_ADD;
    end else begin
      w.finish = 1'b1;
    end
    return w;
  endfunction

endpackage

FILE: hw/rtl/fir_iir_sample_filter.sv
// Top level of the sample filter: microcoded multiply-accumulate sequencer and datapath.
//
//  Port group | Direction | Handshake        | Payload
//  in_        | input     | in_valid/in_stall | in_sample_in, in_restart
//  out_       | output    | out_valid/out_stall | out_sample_out, out_clipped
//  cfg_       | input     | cfg_we            | cfg_index, cfg_data
//
// A sample passes through the accept step, one step per tap on the
// single shared multiplier, one step to drain the accumulator and one to round and retire.
// The retire step waits while the previous result is still held and stalled at the output.
// Synchronous reset clears step, coefficients, histories, out_valid and sets IIR mode.
// A new sample is taken while the last result still waits to be transferred.
module fir_iir_sample_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fisf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fisf_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_clipped,
  input  logic                                cfg_we,
  input  logic [fisf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fisf_pkg::CFG_W-1:0]          cfg_data
);

  localparam int SH_W = fisf_pkg::ACC_W - fisf_pkg::COEF_FRAC_BITS;

  logic                                   iir_mode_r;
  logic [fisf_pkg::CFG_W-1:0]             coef_low_r;
  logic [fisf_pkg::CFG_W-1:0]             coef_mid_r;
  logic [fisf_pkg::COEF_W-1:0]            coef_high_r;

  logic [fisf_pkg::STEP_W-1:0]            step_r, step_nxt;
  fisf_pkg::ctl_t                         ctl;

  logic signed [fisf_pkg::SAMPLE_W-1:0]   x_r;
  logic signed [fisf_pkg::SAMPLE_W-1:0]   hin_r  [fisf_pkg::ORDER];
  logic signed [fisf_pkg::SAMPLE_W-1:0]   hout_r [fisf_pkg::ORDER];
  logic signed [fisf_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [fisf_pkg::ACC_W-1:0]      acc_r, acc_nxt;

  logic                                   out_valid_r;
  logic signed [fisf_pkg::SAMPLE_W-1:0]   out_sample_r;
  logic                                   out_clipped_r;

  logic                                   in_fire;
  logic                                   out_free;
  logic                                   retire;
  logic [fisf_pkg::COEF_ALL_W-1:0]        coef_all;
  logic signed [fisf_pkg::COEF_W-1:0]     coef;
  logic [fisf_pkg::HIST_IDX_W-1:0]        hidx;
  logic signed [fisf_pkg::OPD_W-1:0]      opd;
  logic signed [fisf_pkg::ACC_W-1:0]      rnd;
  logic signed [SH_W-1:0]                 sh;
  logic                                   pos_ovf;
  logic                                   neg_ovf;
  logic signed [fisf_pkg::SAMPLE_W-1:0]   y;

  assign ctl      = fisf_pkg::rom_word(step_r);
  assign in_stall = !ctl.wait_in;
  assign in_fire  = in_valid && ctl.wait_in;
  assign out_free = !out_valid_r || !out_stall;
  assign retire   = ctl.finish && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iir_mode_r  <= 1'b1;
      coef_low_r  <= '0;
      coef_mid_r  <= '0;
      coef_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fisf_pkg::REG_IIR_MODE:  iir_mode_r  <= cfg_data[0];
        fisf_pkg::REG_COEF_LOW:  coef_low_r  <= cfg_data;
        fisf_pkg::REG_COEF_MID:  coef_mid_r  <= cfg_data;
        fisf_pkg::REG_COEF_HIGH: coef_high_r <= cfg_data[fisf_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (ctl.wait_in) begin
      if (in_valid) begin
        step_nxt = fisf_pkg::STEP_W'(1);
      end
    end else if (ctl.finish) begin
      if (out_free) begin
        step_nxt = '0;
      end
    end else begin
      step_nxt = step_r + fisf_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign coef_all = {coef_high_r, coef_mid_r, coef_low_r};

  always_comb begin
    if (int'(ctl.tap) < fisf_pkg::PACKED_TAPS) begin
      coef = coef_all[fisf_pkg::COEF_W*int'(ctl.tap) +: fisf_pkg::COEF_W];
    end else begin
      coef = '0;
    end
    if (ctl.tap == '0) begin
      hidx = '0;
    end else begin
      hidx = fisf_pkg::HIST_IDX_W'(ctl.tap - fisf_pkg::TAP_W'(1));
    end
    if (ctl.tap == '0) begin
      opd = fisf_pkg::OPD_W'(x_r);
    end else if (iir_mode_r) begin
      opd = fisf_pkg::OPD_W'(hin_r[hidx]) - fisf_pkg::OPD_W'(hout_r[hidx]);
    end else begin
      opd = fisf_pkg::OPD_W'(hin_r[hidx]);
    end
    prod_nxt = coef * opd;
  end

  always_comb begin
    acc_nxt = acc_r;
    unique case (ctl.acc_op)
      fisf_pkg::ACC_NONE: acc_nxt = acc_r;
      fisf_pkg::ACC_LOAD: acc_nxt = fisf_pkg::ACC_W'(prod_r);
      fisf_pkg::ACC_ADD:  acc_nxt = acc_r + fisf_pkg::ACC_W'(prod_r);
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (in_fire) begin
      x_r <= in_sample_in;
    end
  end

  always_comb begin
    rnd     = acc_r + fisf_pkg::ACC_W'(1 << (fisf_pkg::COEF_FRAC_BITS - 1));
    sh      = SH_W'(rnd >>> fisf_pkg::COEF_FRAC_BITS);
    pos_ovf = !sh[SH_W-1] && (|sh[SH_W-2:fisf_pkg::SAMPLE_W-1]);
    neg_ovf = sh[SH_W-1] && !(&sh[SH_W-2:fisf_pkg::SAMPLE_W-1]);
    if (pos_ovf) begin
      y = {1'b0, {(fisf_pkg::SAMPLE_W-1){1'b1}}};
    end else if (neg_ovf) begin
      y = {1'b1, {(fisf_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      y = sh[fisf_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < fisf_pkg::ORDER; k++) begin
        hin_r[k]  <= '0;
        hout_r[k] <= '0;
      end
    end else if (in_fire && in_restart) begin
      for (int k = 0; k < fisf_pkg::ORDER; k++) begin
        hin_r[k]  <= '0;
        hout_r[k] <= '0;
      end
    end else if (retire) begin
      for (int k = fisf_pkg::ORDER - 1; k > 0; k--) begin
        hin_r[k]  <= hin_r[k-1];
        hout_r[k] <= hout_r[k-1];
      end
      hin_r[0]  <= x_r;
      hout_r[0] <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (retire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_sample_r  <= y;
      out_clipped_r <= pos_ovf || neg_ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

FILE: tb/fir_iir_sample_filter_checker.sv
// Checker for the sample filter: follows the register writes, predicts each filtered sample and compares.
module fir_iir_sample_filter_checker
  import fisf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_restart,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       out_clipped,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         mismatch_count,
  output int                         filtered_pending
);

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } filtered_t;

  filtered_t                  filtered_q[$];
  logic                       iir_on;
  logic [CFG_W-1:0]           coef_low;
  logic [CFG_W-1:0]           coef_mid;
  logic [COEF_W-1:0]          coef_high;
  logic signed [SAMPLE_W-1:0] x_hist[ORDER];
  logic signed [SAMPLE_W-1:0] y_hist[ORDER];

  function automatic longint tap_value(int k);
    logic signed [COEF_W-1:0] c;
    if (k < 4) begin
      c = coef_low[COEF_W*k +: COEF_W];
    end else if (k < 8) begin
      c = coef_mid[COEF_W*(k-4) +: COEF_W];
    end else if (k == 8) begin
      c = coef_high;
    end else begin
      c = '0;
    end
    return longint'(c);
  endfunction

  function automatic void clear_history();
    for (int k = 0; k < ORDER; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
  endfunction

  task automatic filter_sample(input logic signed [SAMPLE_W-1:0] x, input logic restart);
    longint    acc;
    longint    diff;
    longint    y;
    filtered_t r;
    if (restart) begin
      clear_history();
    end
    acc = tap_value(0) * longint'(x);
    for (int j = 1; j <= ORDER; j++) begin
      diff = longint'(x_hist[j-1]);
      if (iir_on) begin
        diff = diff - longint'(y_hist[j-1]);
      end
      acc = acc + tap_value(j) * diff;
    end
    y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    r.clipped = 1'b0;
    if (y > SAT_HI) begin
      y = SAT_HI;
      r.clipped = 1'b1;
    end else if (y < SAT_LO) begin
      y = SAT_LO;
      r.clipped = 1'b1;
    end
    r.sample = SAMPLE_W'(y);
    for (int k = ORDER - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = r.sample;
    filtered_q = {filtered_q, r};
  endtask

  always @(posedge clk) begin
    filtered_t want;
    if (!rst_n) begin
      iir_on = 1'b1;
      coef_low = '0;
      coef_mid = '0;
      coef_high = '0;
      clear_history();
      filtered_q.delete();
      mismatch_count = 0;
      filtered_pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected transfer: out_sample_out=%0d out_clipped=%0b",
                 out_sample_out, out_clipped);
          mismatch_count++;
        end else begin
          want = filtered_q.pop_front();
          if (out_sample_out !== want.sample) begin
            $error("out_sample_out: expected %0d, got %0d", want.sample, out_sample_out);
            mismatch_count++;
          end
          if (out_clipped !== want.clipped) begin
            $error("out_clipped: expected %0b, got %0b", want.clipped, out_clipped);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_IIR_MODE:  iir_on = cfg_data[0];
          REG_COEF_LOW:  coef_low = cfg_data;
          REG_COEF_MID:  coef_mid = cfg_data;
          REG_COEF_HIGH: coef_high = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        filter_sample(in_sample_in, in_restart);
      end
      filtered_pending = filtered_q.size();
    end
  end

endmodule

FILE: tb/fir_iir_sample_filter_tb.sv
// Testbench top for the sample filter: clock, reset, stimulus, back-pressure and the verdict.
module fir_iir_sample_filter_tb;
  import fisf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 45;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_clipped;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  int                         mismatch_count;
  int                         filtered_pending;
  int                         cycle_count = 0;
  int                         send_calm = 0;
  int                         recv_calm = 0;

  fir_iir_sample_filter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  fir_iir_sample_filter_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_clipped      (out_clipped),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .filtered_pending (filtered_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fir_iir_sample_filter_tb failed");
      $finish;
    end
  end

  // Runs of zero-wait items alternate with random waits.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 30);
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hffff;
        endcase
      end
      1, 2: return SAMPLE_W'($urandom);
      default: return SAMPLE_W'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_tap(int style);
    case (style)
      0: return COEF_W'($urandom_range(0, 2048) - 1024);
      1: return COEF_W'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'h4000;
        endcase
      end
      default: return COEF_W'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs(input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] mid,
                            input logic [CFG_W-1:0] high);
    write_reg(REG_COEF_LOW, low);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_HIGH, high);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic restart);
    int gap;
    gap = draw_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the sender off until every predicted sample has been transferred.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_pending != 0) @(negedge clk);
    repeat (2 * NUM_STEPS) @(negedge clk);
  endtask

  initial begin
    int hold;
    forever begin
      hold = draw_gap(recv_calm);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    int                 style;
    logic [COEF_W-1:0]  taps[PACKED_TAPS];
    logic [CFG_W-1:0]   low;
    logic [CFG_W-1:0]   mid;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: recursive form with all taps zero.
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    drain();

    write_reg(REG_IIR_MODE, '0);
    load_coefs(64'h4000, '0, '0);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hffff, 1'b0);
    drain();

    // Rounding half up at the smallest tap.
    load_coefs(64'h1, '0, '0);
    send_sample(16'h2000, 1'b0);
    send_sample(16'he000, 1'b0);
    send_sample(16'h1fff, 1'b0);
    send_sample(16'hdfff, 1'b0);
    drain();

    load_coefs(64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff, 64'h7fff);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    drain();

    load_coefs(64'h8000_8000_8000_8000, '0, 64'hffff_ffff_ffff_8000);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h8000, 1'b0);
    drain();

    // Switch to the recursive form without a restart, so it sees the history left by FIR mode.
    write_reg(REG_IIR_MODE, 64'h1);
    load_coefs(64'h0000_0000_2000_4000, '0, 64'h1000);
    send_sample(16'd12000, 1'b0);
    send_sample(-16'sd20000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd5000, 1'b1);
    send_sample(16'd100, 1'b0);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      write_reg(REG_IIR_MODE, {$urandom, 31'($urandom_range(0, 32767)), phase[0]});
      if (phase == 7) begin
        load_coefs('1, '1, '1);
      end else if (phase == 8) begin
        load_coefs('0, '0, '0);
      end else begin
        style = $urandom_range(0, 3);
        foreach (taps[k]) taps[k] = pick_tap(style);
        low = {taps[3], taps[2], taps[1], taps[0]};
        mid = {taps[7], taps[6], taps[5], taps[4]};
        load_coefs(low, mid, {$urandom, 16'($urandom_range(0, 65535)), taps[8]});
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_sample(), $urandom_range(0, 15) == 0);
        if (phase == 3 && n == 20) begin
          drain();
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("fir_iir_sample_filter_tb passed");
    end else begin
      $display("fir_iir_sample_filter_tb failed");
    end
    $finish;
  end

endmodule

FILE: fir_iir_sample_filter.f
hw/rtl/fisf_pkg.sv
hw/rtl/fir_iir_sample_filter.sv
tb/fir_iir_sample_filter_checker.sv
tb/fir_iir_sample_filter_tb.sv
